[design/gbh_pkg.sv]
// Shared types and constants for the grid binning height average block.
// Used by gbh_divider, gbh_cell_mem and grid_binning_height_average_unit.
// No dependencies.
package gbh_pkg;

   // item kinds
   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // configuration register indexes
   localparam logic [2:0] CSR_MIN_X   = 3'd0;
   localparam logic [2:0] CSR_MAX_X   = 3'd1;
   localparam logic [2:0] CSR_MIN_Y   = 3'd2;
   localparam logic [2:0] CSR_MAX_Y   = 3'd3;
   localparam logic [2:0] CSR_MIN_Z   = 3'd4;
   localparam logic [2:0] CSR_MAX_Z   = 3'd5;
   localparam logic [2:0] CSR_COLUMNS = 3'd6;
   localparam logic [2:0] CSR_ROWS    = 3'd7;

   // axis being binned
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // shared divider geometry: numerator/denominator, 16 quotient bits
   localparam int DIV_NUM_W = 48;
   localparam int DIV_DEN_W = 32;
   localparam int DIV_Q_W   = 16;
   localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] numer;
      logic [DIV_DEN_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [DIV_Q_W-1:0] quot;
   } div_rsp_type;

endpackage

[design/gbh_divider.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Requires numer[47:16] < denom, so the quotient fits 16 bits.
// Depends on gbh_pkg.
module gbh_divider (
   input  logic                clock,
   input  logic                reset,
   input  gbh_pkg::div_req_type req,
   output gbh_pkg::div_rsp_type rsp
);
   import gbh_pkg::*;

   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_Q_W-1:0]   shr_ff, shr_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;

   // one trial subtract per cycle
   always_comb begin
      trial = {rem_ff, shr_ff[DIV_Q_W-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = trial >= {1'b0, den_ff};
   end

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      shr_in  = shr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = req.numer[DIV_NUM_W-1:DIV_Q_W];
         shr_in  = req.numer[DIV_Q_W-1:0];
         den_in  = req.denom;
         step_in = DIV_CNT_W'(DIV_Q_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // low bits of the shift register fill with quotient bits
         rem_in  = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         shr_in  = {shr_ff[DIV_Q_W-2:0], fits};
         step_in = step_ff - DIV_CNT_W'(1);
         if (step_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      shr_ff <= shr_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = shr_ff;

endmodule

[design/gbh_cell_mem.sv]
// Per-cell storage of height sum and point count, one write and one read port.
// Read data is registered. Depends on gbh_pkg only by convention.
module gbh_cell_mem #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12,
   parameter int DATA_W = 48
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);
   import gbh_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/grid_binning_height_average_unit.sv]
// Top level: bins points into a 2D grid and reports per-cell mean height.
// Depends on gbh_pkg, gbh_divider and gbh_cell_mem.
//
//   channel  direction  handshake          payload
//   req      in         valid / stall      kind, x/y/z coords, cell index
//   rsp      out        valid / stall      mean, count, empty, saturated
//   csr      in         valid / ready      index, data
//
// An add item runs, per axis, a subtract, a range check, a divider start and a divider wait
// (the last two skipped when that axis needs no division), then address, memory read and
// update. A read item runs memory read, mean, divider start and wait (skipped when the mean
// needs no division) and response, and holds in its last state while an earlier
// result sits stalled in the output register; a clear item is done in the idle state.
// After reset a clearing pass writes every cell, with req_stall high.
module grid_binning_height_average_unit #(
   parameter int GRID_COLUMNS = 64,
   parameter int GRID_ROWS    = 64,
   parameter int COUNT_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic signed [31:0] req_x_coord,
   input  logic signed [31:0] req_y_coord,
   input  logic signed [31:0] req_z_coord,
   input  logic [11:0] req_cell_index,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_mean_height,
   output logic [15:0] rsp_point_count,
   output logic        rsp_empty_res,
   output logic        rsp_count_saturated,
   // configuration port
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import gbh_pkg::*;

   localparam int CELL_TOTAL = GRID_COLUMNS * GRID_ROWS;
   localparam int CELL_AW    = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;
   localparam int MEM_W      = 32 + COUNT_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [31:0] CELL_TOTAL_W = 32'(CELL_TOTAL);
   localparam logic [31:0] COLUMNS_W    = 32'(GRID_COLUMNS);
   localparam logic [10:0] COL_LIMIT    = 11'(GRID_COLUMNS);
   localparam logic [10:0] ROW_LIMIT    = 11'(GRID_ROWS);

   typedef enum logic [10:0] {
      ST_CLEAR    = 11'b000_0000_0001,
      ST_IDLE     = 11'b000_0000_0010,
      ST_PREP     = 11'b000_0000_0100,
      ST_CHECK    = 11'b000_0000_1000,
      ST_DIV_GO   = 11'b000_0001_0000,
      ST_DIV_WAIT = 11'b000_0010_0000,
      ST_ADDR     = 11'b000_0100_0000,
      ST_RD       = 11'b000_1000_0000,
      ST_UPD      = 11'b001_0000_0000,
      ST_MEAN     = 11'b010_0000_0000,
      ST_RESP     = 11'b100_0000_0000
   } state_type;

   // control state
   state_type state_ff, state_in;
   logic [CELL_AW-1:0] clr_addr_ff, clr_addr_in;
   logic [1:0]  axis_ff, axis_in;
   logic        op_read_ff, op_read_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // configuration registers
   logic signed [31:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff, min_z_ff, max_z_ff;
   logic [6:0]  columns_ff, rows_ff;

   // item working registers
   logic signed [31:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [32:0] d_ff, d_in, r_ff, r_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [6:0]  col_ff, col_in, row_ff, row_in;
   logic [15:0] h_ff, h_in;
   logic [CELL_AW-1:0] addr_ff, addr_in;
   logic        in_grid_ff, in_grid_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [15:0] mean_ff, mean_in;

   // output registers
   logic [15:0] out_mean_ff, out_mean_in, out_count_ff, out_count_in;
   logic        out_empty_ff, out_empty_in, out_sat_ff, out_sat_in;

   // datapath helpers
   div_req_type div_req;
   div_rsp_type div_rsp;
   logic               mem_wr_en, mem_rd_en;
   logic [CELL_AW-1:0] mem_wr_addr;
   logic [MEM_W-1:0]   mem_wr_data, mem_rd_data;
   logic [31:0]        rd_sum;
   logic [COUNT_BITS-1:0] rd_count;
   logic [31:0]        idx_ext;
   logic               idx_in_grid;
   logic [6:0]         res_x, res_y, res_sel;
   logic signed [31:0] v_sel, lo_sel, hi_sel;
   logic               d_pos, r_pos;
   logic [38:0]        prod;
   logic [32:0]        sum_next;
   logic [31:0]        cell_flat;
   logic [31:0]        sel_sum;
   logic [COUNT_BITS-1:0] sel_cnt;
   logic [31:0]        cnt_wide;
   logic [31:0]        cnt_out_wide;
   logic               axis_fin;
   logic [15:0]        axis_val;

   // effective resolutions: zero counts as one, capped at the grid size
   always_comb begin
      if (columns_ff == 7'd0) begin
         res_x = 7'd1;
      end else if ({4'b0, columns_ff} > COL_LIMIT) begin
         res_x = COL_LIMIT[6:0];
      end else begin
         res_x = columns_ff;
      end
      if (rows_ff == 7'd0) begin
         res_y = 7'd1;
      end else if ({4'b0, rows_ff} > ROW_LIMIT) begin
         res_y = ROW_LIMIT[6:0];
      end else begin
         res_y = rows_ff;
      end
   end

   // operand select for the axis in work
   always_comb begin
      unique case (axis_ff)
         AXIS_X: begin
            v_sel = x_ff; lo_sel = min_x_ff; hi_sel = max_x_ff; res_sel = res_x;
         end
         AXIS_Y: begin
            v_sel = y_ff; lo_sel = min_y_ff; hi_sel = max_y_ff; res_sel = res_y;
         end
         default: begin
            v_sel = z_ff; lo_sel = min_z_ff; hi_sel = max_z_ff; res_sel = res_x;
         end
      endcase
   end

   assign d_pos    = !d_ff[32] && (d_ff != 33'sd0);
   assign r_pos    = !r_ff[32] && (r_ff != 33'sd0);
   assign prod     = {7'b0, d_ff[31:0]} * {32'b0, res_sel};
   assign rd_sum   = mem_rd_data[MEM_W-1:COUNT_BITS];
   assign rd_count = mem_rd_data[COUNT_BITS-1:0];
   assign sum_next = {1'b0, rd_sum} + {17'b0, h_ff};
   assign idx_ext  = {20'b0, req_cell_index};
   assign idx_in_grid = idx_ext < CELL_TOTAL_W;
   assign cell_flat   = 32'(row_ff) * COLUMNS_W + 32'(col_ff);
   assign sel_sum  = in_grid_ff ? rd_sum : 32'd0;
   assign sel_cnt  = in_grid_ff ? rd_count : '0;
   assign cnt_wide = 32'(sel_cnt);
   assign cnt_out_wide = 32'(cnt_ff);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      axis_in      = axis_ff;
      op_read_in   = op_read_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      d_in = d_ff; r_in = r_ff;
      num_in = num_ff; den_in = den_ff;
      col_in = col_ff; row_in = row_ff; h_in = h_ff;
      addr_in      = addr_ff;
      in_grid_in   = in_grid_ff;
      cnt_in       = cnt_ff;
      mean_in      = mean_ff;
      out_mean_in  = out_mean_ff;
      out_count_in = out_count_ff;
      out_empty_in = out_empty_ff;
      out_sat_in   = out_sat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_req.start = 1'b0;
      div_req.numer = num_ff;
      div_req.denom = den_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = clr_addr_ff;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      axis_fin    = 1'b0;
      axis_val    = 16'd0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en = 1'b1;
            clr_addr_in = clr_addr_ff + CELL_AW'(1);
            if (clr_addr_ff == CELL_AW'(CELL_TOTAL - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  KIND_ADD: begin
                     x_in = req_x_coord; y_in = req_y_coord; z_in = req_z_coord;
                     axis_in    = AXIS_X;
                     op_read_in = 1'b0;
                     state_in   = ST_PREP;
                  end
                  KIND_READ: begin
                     addr_in    = idx_ext[CELL_AW-1:0];
                     in_grid_in = idx_in_grid;
                     op_read_in = 1'b1;
                     state_in   = ST_RD;
                  end
                  KIND_CLEAR: begin
                     mem_wr_en   = idx_in_grid;
                     mem_wr_addr = idx_ext[CELL_AW-1:0];
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PREP: begin
            d_in = {v_sel[31], v_sel} - {lo_sel[31], lo_sel};
            r_in = {hi_sel[31], hi_sel} - {lo_sel[31], lo_sel};
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!r_pos || !d_pos) begin
               axis_fin = 1'b1;
            end else if (d_ff[31:0] >= r_ff[31:0]) begin
               // at or past the top of the range
               axis_fin = 1'b1;
               axis_val = (axis_ff == AXIS_Z) ? 16'hFFFF : {9'b0, res_sel - 7'd1};
            end else begin
               num_in = (axis_ff == AXIS_Z) ? {d_ff[31:0], 16'b0} : {9'b0, prod};
               den_in = r_ff[31:0];
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            div_req.start = 1'b1;
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               if (op_read_ff) begin
                  mean_in  = div_rsp.quot;
                  state_in = ST_RESP;
               end else begin
                  axis_fin = 1'b1;
                  axis_val = div_rsp.quot;
               end
            end
         end
         ST_ADDR: begin
            addr_in  = cell_flat[CELL_AW-1:0];
            state_in = ST_RD;
         end
         ST_RD: begin
            mem_rd_en = 1'b1;
            state_in  = op_read_ff ? ST_MEAN : ST_UPD;
         end
         ST_UPD: begin
            // saturated cells ignore further points
            if (rd_count != COUNT_MAX) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = addr_ff;
               mem_wr_data = {(sum_next[32] ? 32'hFFFF_FFFF : sum_next[31:0]),
                              rd_count + COUNT_BITS'(1)};
            end
            state_in = ST_IDLE;
         end
         ST_MEAN: begin
            cnt_in = sel_cnt;
            if (sel_cnt == '0) begin
               mean_in  = 16'd0;
               state_in = ST_RESP;
            end else if ({16'b0, sel_sum} >= {cnt_wide, 16'b0}) begin
               mean_in  = 16'hFFFF;
               state_in = ST_RESP;
            end else begin
               num_in   = {16'b0, sel_sum};
               den_in   = cnt_wide;
               state_in = ST_DIV_GO;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_mean_in  = mean_ff;
               out_count_in = (cnt_out_wide > 32'd65535) ? 16'hFFFF : cnt_out_wide[15:0];
               out_empty_in = cnt_ff == '0;
               out_sat_in   = cnt_ff == COUNT_MAX;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // store one axis result and move on
      if (axis_fin) begin
         case (axis_ff)
            AXIS_X:  col_in = axis_val[6:0];
            AXIS_Y:  row_in = axis_val[6:0];
            default: h_in   = axis_val;
         endcase
         if (axis_ff == AXIS_Z) begin
            state_in = ST_ADDR;
         end else begin
            axis_in  = axis_ff + 2'd1;
            state_in = ST_PREP;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         axis_ff      <= AXIS_X;
         op_read_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         axis_ff      <= axis_in;
         op_read_ff   <= op_read_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      d_ff <= d_in; r_ff <= r_in;
      num_ff <= num_in; den_ff <= den_in;
      col_ff <= col_in; row_ff <= row_in; h_ff <= h_in;
      addr_ff    <= addr_in;
      in_grid_ff <= in_grid_in;
      cnt_ff     <= cnt_in;
      mean_ff    <= mean_in;
      out_mean_ff  <= out_mean_in;
      out_count_ff <= out_count_in;
      out_empty_ff <= out_empty_in;
      out_sat_ff   <= out_sat_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff <= 32'sd0; max_x_ff <= 32'sd256;
         min_y_ff <= 32'sd0; max_y_ff <= 32'sd256;
         min_z_ff <= 32'sd0; max_z_ff <= 32'sd256;
         columns_ff <= 7'd64;
         rows_ff    <= 7'd64;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_X:   min_x_ff   <= csr_data;
            CSR_MAX_X:   max_x_ff   <= csr_data;
            CSR_MIN_Y:   min_y_ff   <= csr_data;
            CSR_MAX_Y:   max_y_ff   <= csr_data;
            CSR_MIN_Z:   min_z_ff   <= csr_data;
            CSR_MAX_Z:   max_z_ff   <= csr_data;
            CSR_COLUMNS: columns_ff <= csr_data[6:0];
            CSR_ROWS:    rows_ff    <= csr_data[6:0];
            default: begin
            end
         endcase
      end
   end

   gbh_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   gbh_cell_mem #(
      .DEPTH  (CELL_TOTAL),
      .ADDR_W (CELL_AW),
      .DATA_W (MEM_W)
   ) u_cell_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (addr_ff),
      .rd_data (mem_rd_data)
   );

   assign req_stall           = state_ff != ST_IDLE;
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mean_height     = out_mean_ff;
   assign rsp_point_count     = out_count_ff;
   assign rsp_empty_res       = out_empty_ff;
   assign rsp_count_saturated = out_sat_ff;

   // divider results arrive only while the sequencer waits for them
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV_WAIT)
      else $error("divider finished outside wait state");

   // the divider is never restarted while busy
   a_div_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider restarted while busy");

   // cell memory is written only by the sweep, a clear item or an update
   a_mem_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_IDLE || state_ff == ST_UPD))
      else $error("cell memory written in wrong state");

   // an empty cell reports a zero mean and zero count
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_mean_height == 16'd0 && rsp_point_count == 16'd0)
      else $error("empty cell with nonzero mean or count");

endmodule

[tb/testbench.sv]
// Testbench for grid_binning_height_average_unit: directed and random add, read and clear
// items, with each read checked against a cell store modeled inside the bench.
// Depends on gbh_pkg and the block's RTL; needs no other file.
module testbench;
   import gbh_pkg::*;

   // kind code the block must ignore
   localparam logic [1:0] KIND_NONE = 2'd3;
   localparam int CELLS         = 4096;
   localparam int GRID_DIM      = 64;
   localparam int IDLE_PCT      = 14;
   localparam int HOLD_CYCLES   = 600;
   localparam int SETTLE_CYCLES = 150;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [11:0]        cell_idx;
   } grid_cmd_t;

   typedef struct packed {
      logic [15:0] mean;
      logic [15:0] count;
      logic        empty;
      logic        saturated;
   } cell_report_t;

   logic               clock;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_stall;
   logic [1:0]         req_kind       = KIND_ADD;
   logic signed [31:0] req_x_coord    = '0;
   logic signed [31:0] req_y_coord    = '0;
   logic signed [31:0] req_z_coord    = '0;
   logic [11:0]        req_cell_index = '0;
   logic               rsp_valid;
   logic               rsp_stall      = 1'b0;
   logic [15:0]        rsp_mean_height;
   logic [15:0]        rsp_point_count;
   logic               rsp_empty_res;
   logic               rsp_count_saturated;
   logic               csr_valid      = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index      = CSR_MIN_X;
   logic [31:0]        csr_data       = '0;

   // shadow of the range and resolution registers
   logic signed [31:0] lo_bound [3];
   logic signed [31:0] hi_bound [3];
   logic [6:0]         cols_reg = 7'd64;
   logic [6:0]         rows_reg = 7'd64;

   // modeled cell store
   logic [31:0] height_sum  [CELLS];
   logic [15:0] point_total [CELLS];

   grid_cmd_t    grid_cmd_queue[$];
   cell_report_t cell_report_queue[$];
   grid_cmd_t    cmd_on_bus;
   cell_report_t report_due;

   int idle_pct       = IDLE_PCT;
   int burst_requests = 0;
   int bursts_served  = 0;
   int hold_left      = 0;
   int fail_count     = 0;

   grid_binning_height_average_unit DUT (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_500_000;
      $display("status: fail");
      $finish;
   end

   function automatic int unsigned eff_res(logic [6:0] r);
      if (r == 0) return 1;
      return (r > GRID_DIM) ? GRID_DIM : r;
   endfunction

   // cell coordinate along one axis, clamped to 0..res-1
   function automatic int unsigned axis_bin(longint v, longint lo, longint hi,
                                            int unsigned res);
      longint span, delta, q;
      span  = hi - lo;
      delta = v - lo;
      if (span <= 0 || delta <= 0) return 0;
      q = (delta * longint'(res)) / span;
      return (q >= res) ? res - 1 : 32'(q);
   endfunction

   // height as a Q0.16 fraction of the z range
   function automatic int unsigned height_frac(longint v, longint lo, longint hi);
      longint span, delta, q;
      span  = hi - lo;
      delta = v - lo;
      if (span <= 0 || delta <= 0) return 0;
      q = (delta <<< 16) / span;
      return (q > 65535) ? 65535 : 32'(q);
   endfunction

   // update the cell store for one accepted item, queue the report of a read
   task automatic apply_grid_command(input grid_cmd_t c);
      int unsigned    col, row, h, idx;
      longint         total;
      logic [31:0]    mean32;
      cell_report_t   rep;
      case (c.kind)
         KIND_ADD: begin
            col = axis_bin($signed(c.x), lo_bound[AXIS_X], hi_bound[AXIS_X],
                           eff_res(cols_reg));
            row = axis_bin($signed(c.y), lo_bound[AXIS_Y], hi_bound[AXIS_Y],
                           eff_res(rows_reg));
            h   = height_frac($signed(c.z), lo_bound[AXIS_Z], hi_bound[AXIS_Z]);
            idx = row * GRID_DIM + col;
            // a full cell ignores further points
            if (point_total[idx] != 16'hFFFF) begin
               point_total[idx] = point_total[idx] + 16'd1;
               total = longint'(height_sum[idx]) + longint'(h);
               height_sum[idx] = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
            end
         end
         KIND_READ: begin
            rep.count     = point_total[c.cell_idx];
            rep.empty     = (point_total[c.cell_idx] == 16'd0);
            rep.saturated = (point_total[c.cell_idx] == 16'hFFFF);
            rep.mean      = '0;
            if (!rep.empty) begin
               mean32   = height_sum[c.cell_idx] / point_total[c.cell_idx];
               rep.mean = (mean32 > 32'd65535) ? 16'hFFFF : mean32[15:0];
            end
            cell_report_queue.push_back(rep);
         end
         KIND_CLEAR: begin
            height_sum[c.cell_idx]  = '0;
            point_total[c.cell_idx] = '0;
         end
         default: ;
      endcase
   endtask

   // driver: offers queued items, predicts each one as it is accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) apply_grid_command(cmd_on_bus);
         if (!req_valid || !req_stall) begin
            if (grid_cmd_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
               cmd_on_bus = grid_cmd_queue.pop_front();
               req_valid      <= 1'b1;
               req_kind       <= cmd_on_bus.kind;
               req_x_coord    <= cmd_on_bus.x;
               req_y_coord    <= cmd_on_bus.y;
               req_z_coord    <= cmd_on_bus.z;
               req_cell_index <= cmd_on_bus.cell_idx;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: random stall, long hold-off on request, check of each read report
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (bursts_served != burst_requests) begin
         rsp_stall     <= 1'b1;
         hold_left     <= HOLD_CYCLES;
         bursts_served <= bursts_served + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end

      if (!reset && rsp_valid && !rsp_stall) begin
         if (cell_report_queue.size() == 0) begin
            $error("unexpected report: mean_height %0d point_count %0d",
                   rsp_mean_height, rsp_point_count);
            fail_count++;
         end else begin
            report_due = cell_report_queue.pop_front();
            if (rsp_mean_height !== report_due.mean) begin
               $error("mean_height: expected %0d, actual %0d",
                      report_due.mean, rsp_mean_height);
               fail_count++;
            end
            if (rsp_point_count !== report_due.count) begin
               $error("point_count: expected %0d, actual %0d",
                      report_due.count, rsp_point_count);
               fail_count++;
            end
            if (rsp_empty_res !== report_due.empty) begin
               $error("empty_res: expected %0d, actual %0d",
                      report_due.empty, rsp_empty_res);
               fail_count++;
            end
            if (rsp_count_saturated !== report_due.saturated) begin
               $error("count_saturated: expected %0d, actual %0d",
                      report_due.saturated, rsp_count_saturated);
               fail_count++;
            end
         end
      end
   end

   function automatic grid_cmd_t mk_cmd(logic [1:0] kind, logic signed [31:0] x,
                                        logic signed [31:0] y, logic signed [31:0] z,
                                        logic [11:0] cell_idx);
      grid_cmd_t c;
      c.kind     = kind;
      c.x        = x;
      c.y        = y;
      c.z        = z;
      c.cell_idx = cell_idx;
      return c;
   endfunction

   // coordinate mostly inside the configured range, with some spill and noise
   function automatic logic signed [31:0] coord_near(logic signed [31:0] lo,
                                                     logic signed [31:0] hi);
      longint lo_l, hi_l, span, margin, pick;
      lo_l = lo;
      hi_l = hi;
      if (hi_l <= lo_l || $urandom_range(9) == 0) return $urandom;
      if ($urandom_range(19) == 0) return ($urandom_range(1) == 0) ? lo : hi;
      span   = hi_l - lo_l;
      margin = span / 8;
      pick   = lo_l - margin + longint'({$urandom, $urandom} % (span + 2 * margin + 1));
      if (pick < -64'sd2147483648) pick = -64'sd2147483648;
      if (pick > 64'sd2147483647) pick = 64'sd2147483647;
      return pick[31:0];
   endfunction

   // cell index, mostly inside the used part of the grid
   function automatic logic [11:0] pick_cell();
      int unsigned row, col;
      if ($urandom_range(99) < 15) return 12'($urandom);
      row = $urandom_range(eff_res(rows_reg) - 1);
      col = $urandom_range(eff_res(cols_reg) - 1);
      return 12'(row * GRID_DIM + col);
   endfunction

   function automatic grid_cmd_t make_random_cmd(bit reads_only);
      grid_cmd_t   c;
      int unsigned roll;
      roll   = reads_only ? 60 : $urandom_range(99);
      // unused fields carry noise
      c.x        = $urandom;
      c.y        = $urandom;
      c.z        = $urandom;
      c.cell_idx = 12'($urandom);
      if (roll < 60) begin
         c.kind = KIND_ADD;
         c.x    = coord_near(lo_bound[AXIS_X], hi_bound[AXIS_X]);
         c.y    = coord_near(lo_bound[AXIS_Y], hi_bound[AXIS_Y]);
         c.z    = coord_near(lo_bound[AXIS_Z], hi_bound[AXIS_Z]);
      end else if (roll < 92) begin
         c.kind     = KIND_READ;
         c.cell_idx = pick_cell();
      end else if (roll < 97) begin
         c.kind     = KIND_CLEAR;
         c.cell_idx = pick_cell();
      end else begin
         c.kind = KIND_NONE;
      end
      return c;
   endfunction

   // wait until nothing is queued, offered or awaited, then let adds finish
   task automatic wait_drained();
      do @(negedge clock);
      while (grid_cmd_queue.size() != 0 || req_valid || cell_report_queue.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // one register write; called right after a rising edge, leaves csr_valid high
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock);
      while (!csr_ready);
      case (idx)
         CSR_MIN_X:   lo_bound[AXIS_X] = val;
         CSR_MAX_X:   hi_bound[AXIS_X] = val;
         CSR_MIN_Y:   lo_bound[AXIS_Y] = val;
         CSR_MAX_Y:   hi_bound[AXIS_Y] = val;
         CSR_MIN_Z:   lo_bound[AXIS_Z] = val;
         CSR_MAX_Z:   hi_bound[AXIS_Z] = val;
         CSR_COLUMNS: cols_reg = val[6:0];
         CSR_ROWS:    rows_reg = val[6:0];
         default: ;
      endcase
   endtask

   task automatic set_grid(input logic [31:0] min_x, input logic [31:0] max_x,
                           input logic [31:0] min_y, input logic [31:0] max_y,
                           input logic [31:0] min_z, input logic [31:0] max_z,
                           input logic [31:0] cols, input logic [31:0] rows);
      @(posedge clock);
      write_reg(CSR_MIN_X, min_x);
      write_reg(CSR_MAX_X, max_x);
      write_reg(CSR_MIN_Y, min_y);
      write_reg(CSR_MAX_Y, max_y);
      write_reg(CSR_MIN_Z, min_z);
      write_reg(CSR_MAX_Z, max_z);
      write_reg(CSR_COLUMNS, cols);
      write_reg(CSR_ROWS, rows);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input int count);
      @(negedge clock);
      repeat (count) grid_cmd_queue.push_back(make_random_cmd(1'b0));
      wait_drained();
   endtask

   // main sequence
   initial begin
      int n;
      for (n = 0; n < CELLS; n++) begin
         height_sum[n]  = '0;
         point_total[n] = '0;
      end
      for (n = 0; n < 3; n++) begin
         lo_bound[n] = 32'sd0;
         hi_bound[n] = 32'sd256;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed items on the reset grid (0..256 on each axis, 64 x 64)
      @(negedge clock);
      grid_cmd_queue.push_back(mk_cmd(KIND_ADD, 0, 0, 0, 0));
      grid_cmd_queue.push_back(mk_cmd(KIND_ADD, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000, 0));
      grid_cmd_queue.push_back(mk_cmd(KIND_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      32'h7FFF_FFFF, 0));
      grid_cmd_queue.push_back(mk_cmd(KIND_ADD, 128, 64, 128, 0));
      grid_cmd_queue.push_back(mk_cmd(KIND_ADD, 128, 64, 256, 0));
      grid_cmd_queue.push_back(mk_cmd(KIND_ADD, 255, 255, 255, 0));
      grid_cmd_queue.push_back(mk_cmd(KIND_ADD, 32'h5555_5555, 32'h5555_5555,
                                      32'h5555_5555, 12'hAAA));
      grid_cmd_queue.push_back(mk_cmd(KIND_ADD, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                                      32'hAAAA_AAAA, 12'h555));
      grid_cmd_queue.push_back(mk_cmd(KIND_ADD, 255, 0, 1, 0));
      grid_cmd_queue.push_back(mk_cmd(KIND_READ, 0, 0, 0, 12'd0));
      grid_cmd_queue.push_back(mk_cmd(KIND_READ, 0, 0, 0, 12'hFFF));
      grid_cmd_queue.push_back(mk_cmd(KIND_READ, 0, 0, 0, 12'd1056));
      grid_cmd_queue.push_back(mk_cmd(KIND_READ, 0, 0, 0, 12'd63));
      grid_cmd_queue.push_back(mk_cmd(KIND_READ, 0, 0, 0, 12'd1));
      // ignored kind, every bit set
      grid_cmd_queue.push_back(mk_cmd(KIND_NONE, -1, -1, -1, 12'hFFF));
      grid_cmd_queue.push_back(mk_cmd(KIND_CLEAR, 0, 0, 0, 12'd1056));
      grid_cmd_queue.push_back(mk_cmd(KIND_READ, 0, 0, 0, 12'd1056));
      grid_cmd_queue.push_back(mk_cmd(KIND_CLEAR, -1, -1, -1, 12'hFFF));
      grid_cmd_queue.push_back(mk_cmd(KIND_READ, 0, 0, 0, 12'hFFF));
      grid_cmd_queue.push_back(mk_cmd(KIND_CLEAR, 0, 0, 0, 12'd0));
      grid_cmd_queue.push_back(mk_cmd(KIND_READ, 0, 0, 0, 12'd0));
      grid_cmd_queue.push_back(mk_cmd(KIND_READ, 0, 0, 0, 12'hAAA));
      grid_cmd_queue.push_back(mk_cmd(KIND_READ, 0, 0, 0, 12'h555));
      wait_drained();

      // full signed ranges; column register above the grid, row register zero
      set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FF80);
      run_random(200);

      // narrow ranges on a small grid so cells collect many points
      set_grid(-32'sd1024, 32'sd1024, -32'sd512, 32'sd512, 32'sd0, 32'sd4096, 8, 4);
      run_random(300);

      // inverted and empty ranges: every point lands in cell 0 with height 0
      set_grid(32'h7FFF_FFFF, 32'h8000_0000, 32'sd5, 32'sd5, 32'sd100, -32'sd100, 1, 64);
      run_random(100);

      // full grid, column register past the limit
      set_grid(32'sd0, 32'sd16384, 32'sd0, 32'sd16384, -32'sd256, 32'sd256, 100, 64);
      run_random(400);

      // no idling; receiver holds off while the sender keeps offering reads
      set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'sd0, 32'sd2048, -32'sd65536,
               32'sd65536, 3, 5);
      @(negedge clock);
      idle_pct       = 0;
      burst_requests = burst_requests + 1;
      repeat (40) grid_cmd_queue.push_back(make_random_cmd(1'b1));
      run_random(400);

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[grid_binning_height_average_unit.f]
design/gbh_pkg.sv
design/gbh_divider.sv
design/gbh_cell_mem.sv
design/grid_binning_height_average_unit.sv
tb/testbench.sv
